[src/tsca_pkg.sv]
// Shared types and constants for the tagged saturating cost ALU.
package tsca_pkg;

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_SUM   = 3'd1;
  localparam logic [2:0] ACT_SCALE = 3'd2;
  localparam logic [2:0] ACT_CMP   = 3'd3;
  localparam logic [2:0] ACT_MUL   = 3'd4;

  localparam logic [1:0] GRADE_UNKNOWN = 2'd0;

  localparam logic [1:0] ORD_LESS    = 2'b11;
  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_GREATER = 2'b01;

  localparam logic [63:0] AMT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AMT_MIN = 64'h8000_0000_0000_0000;

  // One quotient bit per divider stage.
  localparam int DIV_STEPS = 63;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  a_grade;
    logic [63:0] a_amount;
    logic [1:0]  b_grade;
    logic [63:0] b_amount;
    logic [62:0] scale_num;
    logic [62:0] scale_den;
  } in_t;

  typedef struct packed {
    logic [1:0]  res_grade;
    logic [63:0] res_amount;
    logic [1:0]  order;
  } out_t;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_MUL,
    KIND_SCALE
  } kind_t;

  // Sideband that travels down the pipeline with each transaction.
  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic [1:0]  grade;
    logic [63:0] amount;
    logic [1:0]  order;
    logic [62:0] den;
  } side_t;

endpackage

[src/tagged_saturating_cost_alu.sv]
// Top level of the tagged saturating cost ALU pipeline.
//
// The block is a fully pipelined, stateless ALU over grade-tagged 64-bit amounts.
// It accepts one transaction per clock while the output side keeps up and
// returns exactly one result per transaction, in order, after these stages:
// one decode stage, three multiplier stages (four 32x32 partial products,
// a middle-term add and a final 128-bit add), one stage that resolves multiply
// saturation and scale overflow, 63 restoring-divider stages that produce one
// quotient bit each, and the output register. Every action takes the same
// path, so latency does not depend on the operation. The whole pipeline moves
// on one enable: it advances whenever the output register is empty or its
// transaction is being taken, so in_ready follows out_ready combinationally
// and a stall holds every stage in place without loss or duplication.
module tagged_saturating_cost_alu (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tsca_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tsca_pkg::out_t out_data
);
  import tsca_pkg::*;

  logic        en;
  logic        f_v, m_v, d_v;
  side_t       f_side, m_side, d_side;
  logic [63:0] f_mx, f_my;
  logic [127:0] m_prod;
  logic [62:0] d_quo;

  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;

  // A bubble or a taken result in the output register lets everything shift.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tsca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .v_o      (f_v),
    .side_o   (f_side),
    .mx_o     (f_mx),
    .my_o     (f_my)
  );

  tsca_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (f_v),
    .side_i (f_side),
    .x_i    (f_mx),
    .y_i    (f_my),
    .v_o    (m_v),
    .side_o (m_side),
    .prod_o (m_prod)
  );

  tsca_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (m_v),
    .side_i (m_side),
    .prod_i (m_prod),
    .v_o    (d_v),
    .side_o (d_side),
    .quo_o  (d_quo)
  );

  // Scale results take the quotient with the sign of the first amount; every
  // other action already carries its final value in the sideband.
  always_comb begin
    out_data_nxt.res_grade = d_side.grade;
    out_data_nxt.order     = d_side.order;
    if (d_side.kind == KIND_SCALE) begin
      out_data_nxt.res_amount = d_side.neg ? (64'd0 - {1'b0, d_quo}) : {1'b0, d_quo};
    end else begin
      out_data_nxt.res_amount = d_side.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/tsca_front.sv]
// Decode stage: direct results for add, sum and compare, multiplier operands otherwise.
module tsca_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tsca_pkg::in_t in_data,
  output logic          v_o,
  output tsca_pkg::side_t side_o,
  output logic [63:0]   mx_o,
  output logic [63:0]   my_o
);
  import tsca_pkg::*;

  logic        v_r;
  side_t       side_r, side_nxt;
  logic [63:0] mx_r, mx_nxt, my_r, my_nxt;

  logic [63:0] a, b, ma, mb, s, sat;
  logic [1:0]  ga, gb, gmin, add_g;
  logic [63:0] add_amt;
  logic        ovf, pa, pb;
  logic [1:0]  ord;

  always_comb begin
    a  = in_data.a_amount;
    b  = in_data.b_amount;
    ga = in_data.a_grade;
    gb = in_data.b_grade;
    ma = a[63] ? (64'd0 - a) : a;
    mb = b[63] ? (64'd0 - b) : b;
    s  = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    sat = ovf ? (a[63] ? AMT_MIN : AMT_MAX) : s;
    gmin = (ga <= gb) ? ga : gb;
    if (ga == GRADE_UNKNOWN || gb == GRADE_UNKNOWN) begin
      add_g   = GRADE_UNKNOWN;
      add_amt = '0;
    end else begin
      add_g   = gmin;
      add_amt = sat;
    end
    pa = (ga != GRADE_UNKNOWN) || (a != '0);
    pb = (gb != GRADE_UNKNOWN) || (b != '0);

    if (ga == GRADE_UNKNOWN && gb == GRADE_UNKNOWN) ord = ORD_EQUAL;
    else if (ga == GRADE_UNKNOWN) ord = ORD_GREATER;
    else if (gb == GRADE_UNKNOWN) ord = ORD_LESS;
    else if ($signed(a) < $signed(b)) ord = ORD_LESS;
    else if ($signed(a) > $signed(b)) ord = ORD_GREATER;
    else if (ga == gb) ord = ORD_EQUAL;
    else if (ga > gb) ord = ORD_LESS;
    else ord = ORD_GREATER;

    side_nxt      = '0;
    side_nxt.kind = KIND_DIRECT;
    side_nxt.den  = in_data.scale_den;
    mx_nxt        = ma;
    my_nxt        = mb;
    unique case (in_data.action)
      ACT_ADD: begin
        side_nxt.grade  = add_g;
        side_nxt.amount = add_amt;
      end
      ACT_SUM: begin
        if (!pa) begin
          side_nxt.grade  = gb;
          side_nxt.amount = (gb != GRADE_UNKNOWN) ? b : '0;
        end else if (!pb) begin
          side_nxt.grade  = ga;
          side_nxt.amount = (ga != GRADE_UNKNOWN) ? a : '0;
        end else begin
          side_nxt.grade  = add_g;
          side_nxt.amount = add_amt;
        end
      end
      ACT_SCALE: begin
        my_nxt = {1'b0, in_data.scale_num};
        // A zero numerator wins over the most negative amount.
        if (ga == GRADE_UNKNOWN || in_data.scale_den == '0) begin
          side_nxt.grade = GRADE_UNKNOWN;
        end else if (in_data.scale_num == '0) begin
          side_nxt.grade = ga;
        end else if (a == AMT_MIN) begin
          side_nxt.grade = GRADE_UNKNOWN;
        end else begin
          side_nxt.kind  = KIND_SCALE;
          side_nxt.grade = ga;
          side_nxt.neg   = a[63];
        end
      end
      ACT_CMP: begin
        side_nxt.order = ord;
      end
      ACT_MUL: begin
        side_nxt.kind = KIND_MUL;
        side_nxt.neg  = a[63] ^ b[63];
      end
      default: begin
        side_nxt.grade = GRADE_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en) begin
      side_r <= side_nxt;
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
    end
  end

  assign v_o    = v_r;
  assign side_o = side_r;
  assign mx_o   = mx_r;
  assign my_o   = my_r;

endmodule

[src/tsca_mul.sv]
// Three-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module tsca_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  tsca_pkg::side_t side_i,
  input  logic [63:0]     x_i,
  input  logic [63:0]     y_i,
  output logic            v_o,
  output tsca_pkg::side_t side_o,
  output logic [127:0]    prod_o
);
  import tsca_pkg::*;

  logic [2:0]   v_r;
  side_t        side1_r, side2_r, side3_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [63:0]  lo2_r, hi2_r;
  logic [64:0]  mid2_r;
  logic [127:0] prod_r, prod_nxt;

  assign prod_nxt = {hi2_r, lo2_r} + {31'd0, mid2_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_i};
    end
    if (en) begin
      ll_r    <= x_i[31:0] * y_i[31:0];
      lh_r    <= x_i[31:0] * y_i[63:32];
      hl_r    <= x_i[63:32] * y_i[31:0];
      hh_r    <= x_i[63:32] * y_i[63:32];
      side1_r <= side_i;
      mid2_r  <= {1'b0, lh_r} + {1'b0, hl_r};
      lo2_r   <= ll_r;
      hi2_r   <= hh_r;
      side2_r <= side1_r;
      prod_r  <= prod_nxt;
      side3_r <= side2_r;
    end
  end

  assign v_o    = v_r[2];
  assign side_o = side3_r;
  assign prod_o = prod_r;

endmodule

[src/tsca_div.sv]
// Overflow resolution followed by a restoring divider, one quotient bit per stage.
module tsca_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  tsca_pkg::side_t side_i,
  input  logic [127:0]    prod_i,
  output logic            v_o,
  output tsca_pkg::side_t side_o,
  output logic [62:0]     quo_o
);
  import tsca_pkg::*;

  logic [DIV_STEPS:0] v_r;
  side_t              side_r [DIV_STEPS+1];
  logic [62:0]        rem_r  [DIV_STEPS+1];
  logic [62:0]        nq_r   [DIV_STEPS+1];

  side_t       res_nxt;
  logic [63:0] limit;
  logic        mul_ovf;

  // The product decides the multiply result and whether a scale overflows.
  always_comb begin
    res_nxt = side_i;
    limit   = side_i.neg ? AMT_MIN : AMT_MAX;
    mul_ovf = (prod_i[127:64] != '0) || (prod_i[63:0] > limit);
    unique case (side_i.kind)
      KIND_MUL: begin
        res_nxt.kind  = KIND_DIRECT;
        res_nxt.grade = GRADE_UNKNOWN;
        if (mul_ovf) res_nxt.amount = limit;
        else if (side_i.neg) res_nxt.amount = 64'd0 - prod_i[63:0];
        else res_nxt.amount = prod_i[63:0];
      end
      KIND_SCALE: begin
        if (prod_i[127:63] != '0) begin
          res_nxt.kind   = KIND_DIRECT;
          res_nxt.grade  = GRADE_UNKNOWN;
          res_nxt.amount = '0;
        end
      end
      default: begin
        res_nxt = side_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
    if (en) begin
      side_r[0] <= res_nxt;
      rem_r[0]  <= '0;
      nq_r[0]   <= prod_i[62:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] trial, diff;
    logic        ge;
    assign trial = {rem_r[k], nq_r[k][62]};
    assign diff  = trial - {1'b0, side_r[k].den};
    assign ge    = trial >= {1'b0, side_r[k].den};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        side_r[k+1] <= side_r[k];
        rem_r[k+1]  <= ge ? diff[62:0] : trial[62:0];
        nq_r[k+1]   <= {nq_r[k][61:0], ge};
      end
    end
  end

  assign v_o    = v_r[DIV_STEPS];
  assign side_o = side_r[DIV_STEPS];
  assign quo_o  = nq_r[DIV_STEPS];

endmodule

[src/tsca_checker.sv]
// Port-level checker for the tagged saturating cost ALU and its bind.
module tsca_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tsca_pkg::out_t out_data
);
  import tsca_pkg::*;

  // A waiting result transaction holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // The pipeline takes input exactly when its output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // A result whose order is not equal carries no grade and no amount.
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.order != ORD_EQUAL |->
      out_data.res_grade == GRADE_UNKNOWN && out_data.res_amount == '0)
    else $error("ordered result with nonzero grade or amount");

  // The order field only ever shows -1, 0 or 1.
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.order != 2'b10)
    else $error("illegal order code");

endmodule

bind tagged_saturating_cost_alu tsca_checker u_tsca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
